[src/rpn_pkg.sv]
// Shared types and constants for the RPN stack evaluator.
// No dependencies; used by every module in src.
package rpn_pkg;

   localparam int WORD_W              = 32;
   localparam int STEP_W              = $clog2(WORD_W);
   localparam int OP_W                = 3;
   localparam int ST_W                = 3;
   localparam int DEPTH_W             = 8;
   localparam int RSP_TDATA_W         = 48;
   localparam int REQ_TDATA_W         = 32;
   localparam int DEFAULT_STACK_DEPTH = 128;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_FINISH = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_DIVZERO   = 3'd2,
      ST_BADDEPTH  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECODE,
      CTL_FETCH,
      CTL_EXEC,
      CTL_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_RUN,
      ALU_FIX,
      ALU_DONE
   } alu_state_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

endpackage

[src/rpn_alu.sv]
// Bit-serial arithmetic unit: add, subtract, multiply, divide (one bit a cycle).
// Depends on rpn_pkg.
module rpn_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  rpn_pkg::alu_cmd_type       cmd,
   input  logic [rpn_pkg::WORD_W-1:0] left,
   input  logic [rpn_pkg::WORD_W-1:0] right,
   output logic                       done,
   output logic [rpn_pkg::WORD_W-1:0] result
);

   rpn_pkg::alu_state_type      state_ff, state_in;
   rpn_pkg::op_type             op_ff, op_in;
   logic [rpn_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [rpn_pkg::WORD_W-1:0]  a_ff, a_in;
   logic [rpn_pkg::WORD_W-1:0]  b_ff, b_in;
   logic [rpn_pkg::WORD_W-1:0]  acc_ff, acc_in;
   logic [rpn_pkg::WORD_W-1:0]  rem_ff, rem_in;
   logic                        carry_ff, carry_in;
   logic                        neg_ff, neg_in;

   logic                        sum_bit;
   logic [rpn_pkg::WORD_W:0]    trial;
   logic [rpn_pkg::WORD_W:0]    diff;
   logic                        ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      step_ff  <= step_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      sum_bit  = a_ff[0] ^ b_ff[0] ^ carry_ff;
      trial    = {rem_ff, a_ff[rpn_pkg::WORD_W-1]};
      diff     = trial - {1'b0, b_ff};
      ge       = (trial >= {1'b0, b_ff});
      done     = 1'b0;

      unique case (state_ff)
         rpn_pkg::ALU_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               step_in  = '0;
               acc_in   = '0;
               rem_in   = '0;
               a_in     = left;
               b_in     = right;
               carry_in = 1'b0;
               neg_in   = left[rpn_pkg::WORD_W-1] ^ right[rpn_pkg::WORD_W-1];
               state_in = rpn_pkg::ALU_RUN;
               if (cmd.op == rpn_pkg::OP_SUB) begin
                  b_in     = ~right;
                  carry_in = 1'b1;
               end else if (cmd.op == rpn_pkg::OP_DIV) begin
                  a_in = left[rpn_pkg::WORD_W-1] ? (~left + 1'b1) : left;
                  b_in = right[rpn_pkg::WORD_W-1] ? (~right + 1'b1) : right;
               end
            end
         end
         rpn_pkg::ALU_RUN: begin
            step_in = step_ff + 1'b1;
            unique case (op_ff)
               rpn_pkg::OP_MUL: begin
                  if (b_ff[0]) begin
                     acc_in = acc_ff + a_ff;
                  end
                  a_in = {a_ff[rpn_pkg::WORD_W-2:0], 1'b0};
                  b_in = {1'b0, b_ff[rpn_pkg::WORD_W-1:1]};
               end
               rpn_pkg::OP_DIV: begin
                  rem_in = ge ? diff[rpn_pkg::WORD_W-1:0] : trial[rpn_pkg::WORD_W-1:0];
                  acc_in = {acc_ff[rpn_pkg::WORD_W-2:0], ge};
                  a_in   = {a_ff[rpn_pkg::WORD_W-2:0], 1'b0};
               end
               default: begin
                  // add and subtract: LSB first ripple through the carry flop
                  acc_in   = {sum_bit, acc_ff[rpn_pkg::WORD_W-1:1]};
                  carry_in = (a_ff[0] & b_ff[0]) | (carry_ff & (a_ff[0] ^ b_ff[0]));
                  a_in     = {1'b0, a_ff[rpn_pkg::WORD_W-1:1]};
                  b_in     = {1'b0, b_ff[rpn_pkg::WORD_W-1:1]};
               end
            endcase
            if (step_ff == rpn_pkg::STEP_W'(rpn_pkg::WORD_W - 1)) begin
               state_in = rpn_pkg::ALU_FIX;
            end
         end
         rpn_pkg::ALU_FIX: begin
            if ((op_ff == rpn_pkg::OP_DIV) && neg_ff) begin
               acc_in = ~acc_ff + 1'b1;
            end
            state_in = rpn_pkg::ALU_DONE;
         end
         rpn_pkg::ALU_DONE: begin
            done     = 1'b1;
            state_in = rpn_pkg::ALU_IDLE;
         end
         default: begin
            state_in = rpn_pkg::ALU_IDLE;
         end
      endcase
   end

   assign result = acc_ff;

endmodule

[src/rpn_stack_evaluator.sv]
// RPN stack evaluator: push, finish and refused or ignored requests go from decode straight
// to the response register; add/sub/mul/div go through the serial unit (one bit a cycle).
// One request at a time: the next is accepted the cycle after the response register is
// loaded. Synchronous active-high reset empties the stack and clears the error;
// stack memory contents are not cleared. Depends on rpn_pkg and rpn_alu.
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rpn_pkg::REQ_TDATA_W-1:0] req_tdata,  // value[31:0]
   input  logic [rpn_pkg::OP_W-1:0]        req_tuser,  // operation[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], top_value[34:3], stack_depth[42:35], zero pad[47:43]
   output logic [rpn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast   // done_res
);

   localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DW    = (CNT_W > rpn_pkg::DEPTH_W) ? CNT_W : rpn_pkg::DEPTH_W;
   localparam int PAD_W = rpn_pkg::RSP_TDATA_W - rpn_pkg::ST_W - rpn_pkg::WORD_W
                          - rpn_pkg::DEPTH_W;

   rpn_pkg::ctl_state_type          state_ff, state_in;
   rpn_pkg::op_type                 op_ff, op_in;
   rpn_pkg::status_type             err_ff, err_in;
   logic [rpn_pkg::WORD_W-1:0]      val_ff, val_in;
   logic [rpn_pkg::WORD_W-1:0]      top_ff, top_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rpn_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [rpn_pkg::WORD_W-1:0]      mem [STACK_DEPTH];
   logic [rpn_pkg::WORD_W-1:0]      rd_data_ff;
   logic                            mem_we;
   logic                            mem_re;
   logic [AW-1:0]                   mem_addr;

   logic [CNT_W-1:0]                cnt_m1;
   logic [CNT_W-1:0]                cnt_m2;
   logic [DW-1:0]                   cnt_wide;
   rpn_pkg::status_type             rsp_status;
   logic [rpn_pkg::WORD_W-1:0]      rsp_top;
   logic [rpn_pkg::DEPTH_W-1:0]     rsp_depth;

   rpn_pkg::alu_cmd_type            alu_cmd;
   logic                            alu_done;
   logic [rpn_pkg::WORD_W-1:0]      alu_result;

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .left   (rd_data_ff),
      .right  (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // entries below the top; the top itself lives in top_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= top_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::CTL_IDLE;
         err_ff       <= rpn_pkg::ST_OK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      val_ff      <= val_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_m2   = count_ff - CNT_W'(2);
   assign cnt_wide = DW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      top_in       = top_ff;
      err_in       = err_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = cnt_m1[AW-1:0];
      alu_cmd      = '{start: 1'b0, op: op_ff};
      req_tready   = 1'b0;
      rsp_depth    = cnt_wide[rpn_pkg::DEPTH_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (op_ff == rpn_pkg::OP_FINISH) begin
         rsp_depth = '0;
         priority if (err_ff != rpn_pkg::ST_OK) begin
            rsp_status = err_ff;
         end else if (count_ff != CNT_W'(1)) begin
            rsp_status = rpn_pkg::ST_BADDEPTH;
         end else begin
            rsp_status = rpn_pkg::ST_OK;
         end
         rsp_top = (rsp_status == rpn_pkg::ST_OK) ? top_ff : '0;
      end else begin
         rsp_status = err_ff;
         rsp_top    = (count_ff == '0) ? '0 : top_ff;
      end

      unique case (state_ff)
         rpn_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = rpn_pkg::op_type'(req_tuser);
               val_in   = req_tdata;
               state_in = rpn_pkg::CTL_DECODE;
            end
         end
         rpn_pkg::CTL_DECODE: begin
            state_in = rpn_pkg::CTL_OUT;
            if ((op_ff != rpn_pkg::OP_FINISH) && (err_ff == rpn_pkg::ST_OK)) begin
               unique case (op_ff)
                  rpn_pkg::OP_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        err_in = rpn_pkg::ST_OVERFLOW;
                     end else begin
                        mem_we   = (count_ff != '0);
                        top_in   = val_ff;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                  rpn_pkg::OP_DIV: begin
                     priority if (count_ff < CNT_W'(2)) begin
                        err_in = rpn_pkg::ST_UNDERFLOW;
                     end else if ((op_ff == rpn_pkg::OP_DIV) && (top_ff == '0)) begin
                        err_in = rpn_pkg::ST_DIVZERO;
                     end else begin
                        mem_re   = 1'b1;
                        mem_addr = cnt_m2[AW-1:0];
                        state_in = rpn_pkg::CTL_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rpn_pkg::CTL_FETCH: begin
            alu_cmd.start = 1'b1;
            state_in      = rpn_pkg::CTL_EXEC;
         end
         rpn_pkg::CTL_EXEC: begin
            if (alu_done) begin
               top_in   = alu_result;
               count_in = cnt_m1;
               state_in = rpn_pkg::CTL_OUT;
            end
         end
         rpn_pkg::CTL_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, rsp_depth, rsp_top, rsp_status};
               rsp_last_in  = (op_ff == rpn_pkg::OP_FINISH);
               state_in     = rpn_pkg::CTL_IDLE;
               if (op_ff == rpn_pkg::OP_FINISH) begin
                  count_in = '0;
                  err_in   = rpn_pkg::ST_OK;
               end
            end
         end
         default: begin
            state_in = rpn_pkg::CTL_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[src/rpn_checker.sv]
// Port-level checks for the RPN stack evaluator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_evaluator.
module rpn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rpn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one in flight");

   a_finish_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[42:35] == 8'd0)
      else $error("finish left entries");

   a_finish_err_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tdata[2:0] != rpn_pkg::ST_OK)
      |-> rsp_tdata[34:3] == 32'd0)
      else $error("failed finish reported a value");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
